// ===== rtl/shifted_delta_cepstra_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Shifted delta cepstra unit: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef SHIFTED_DELTA_CEPSTRA_UNIT_DEFINES_SVH
`define SHIFTED_DELTA_CEPSTRA_UNIT_DEFINES_SVH

// same-cycle implication
`define SDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// Types, constants and codes shared by the shifted delta cepstra unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

    localparam int WINDOW_FRAMES = 128;
    localparam int MAX_COEFS     = 8;
    localparam int VALUE_BITS    = 24;

    localparam int SLOT_BITS  = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
    localparam int COEF_BITS  = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
    localparam int ADDR_BITS  = SLOT_BITS + COEF_BITS;
    localparam int STORE_DEPTH = WINDOW_FRAMES * MAX_COEFS;
    localparam int DELTA_BITS = VALUE_BITS + 1;

    localparam int COUNT_BITS = 16;
    localparam int FRAME_BITS = COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // command codes
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // register indexes
    localparam logic [1:0] REG_NUM_COEFS   = 2'd0;
    localparam logic [1:0] REG_DELTA_DIST  = 2'd1;
    localparam logic [1:0] REG_BLOCK_SHIFT = 2'd2;
    localparam logic [1:0] REG_NUM_BLOCKS  = 2'd3;

    typedef struct packed {
        logic [1:0]                   command;
        logic signed [VALUE_BITS-1:0] coef_value;
    } t_in;

    typedef struct packed {
        logic signed [DELTA_BITS-1:0] delta_value;
        logic [2:0]                   block_index;
        logic [2:0]                   coef_index;
        logic                         last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic push;
        logic start;
        logic emit_begin;
        logic rd;
        logic load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic push_emit;
        logic flush_ok;
        logic out_free;
        logic item_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/sdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdc_ctrl
// Sequencer: takes input transactions, runs the read/load loop per result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shifted_delta_cepstra_unit_defines.svh"

module sdc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_command,
    output logic                   o_in_stall,
    input  wire sdc_pkg::t_dp_stat i_stat,
    output sdc_pkg::t_dp_cmd       o_cmd
);
    import sdc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_command)
                        CMD_PUSH: begin
                            o_cmd.push = 1'b1;
                            if (i_stat.push_emit) begin
                                o_cmd.emit_begin = 1'b1;
                                n_state          = ST_READ;
                            end
                        end
                        CMD_FLUSH: begin
                            if (i_stat.flush_ok) begin
                                o_cmd.emit_begin = 1'b1;
                                n_state          = ST_READ;
                            end
                        end
                        CMD_START: begin
                            o_cmd.start = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.item_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SDC_ASSERT_NEXT(a_read_then_load, r_state == ST_READ, r_state == ST_LOAD, "read not followed by load")
    `SDC_ASSERT_NEXT(a_load_holds, (r_state == ST_LOAD) && !i_stat.out_free, r_state == ST_LOAD, "left load with output busy")

endmodule

`default_nettype wire

// ===== rtl/sdc_datapath.sv =====
// ----------------------------------------------------------------------------
// sdc_datapath
// Config registers, frame store, frame counters, delta subtract, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shifted_delta_cepstra_unit_defines.svh"

module sdc_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sdc_pkg::t_in      i_in_data,
    input  wire logic              i_cfg_valid,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [3:0]        i_cfg_data,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output sdc_pkg::t_out          o_out_data,
    input  wire sdc_pkg::t_dp_cmd  i_cmd,
    output sdc_pkg::t_dp_stat      o_stat
);
    import sdc_pkg::*;

    // config
    logic [3:0] r_num_coefs;
    logic [2:0] r_delta_dist;
    logic [3:0] r_block_shift;
    logic [3:0] r_num_blocks;

    // write side
    logic [SLOT_BITS-1:0]  r_wptr;
    logic [COEF_BITS-1:0]  r_coef_cnt;
    logic [COUNT_BITS-1:0] r_received;
    logic [COUNT_BITS-1:0] r_emitted;

    // emission iteration
    logic [FRAME_BITS-1:0] r_base;
    logic [2:0]            r_blk;
    logic [COEF_BITS-1:0]  r_coef;
    logic                  r_ok_q;
    logic                  r_last_q;
    logic [2:0]            r_blk_q;
    logic [COEF_BITS-1:0]  r_coef_q;
    logic [VALUE_BITS-1:0] r_rd_hi;
    logic [VALUE_BITS-1:0] r_rd_lo;

    logic [VALUE_BITS-1:0] r_frame_store [STORE_DEPTH];

    logic  r_out_valid;
    t_out  r_out;

    logic [3:0]            n_eff;
    logic [3:0]            p_eff;
    logic [3:0]            k_eff;
    logic [6:0]            span;
    logic                  full;
    logic                  frame_done;
    logic [FRAME_BITS-1:0] recv_next;
    logic [FRAME_BITS-1:0] emit_lim;
    logic [FRAME_BITS-1:0] base_hi;
    logic [FRAME_BITS-1:0] base_lo;
    logic                  item_ok;
    logic                  coef_last;
    logic                  blk_last;
    logic [ADDR_BITS-1:0]  addr_wr;
    logic [ADDR_BITS-1:0]  addr_hi;
    logic [ADDR_BITS-1:0]  addr_lo;
    logic [DELTA_BITS-1:0] delta;

    // clamped settings
    always_comb begin
        priority if (r_num_coefs == 4'd0)              n_eff = 4'd1;
        else if (r_num_coefs > 4'(MAX_COEFS))          n_eff = 4'(MAX_COEFS);
        else                                           n_eff = r_num_coefs;
        priority if (r_block_shift == 4'd0)            p_eff = 4'd1;
        else if (r_block_shift > 4'd8)                 p_eff = 4'd8;
        else                                           p_eff = r_block_shift;
        priority if (r_num_blocks == 4'd0)             k_eff = 4'd1;
        else if (r_num_blocks > 4'd8)                  k_eff = 4'd8;
        else                                           k_eff = r_num_blocks;
    end

    // look-ahead needed before frame t can go out: (k-1)*P + d
    assign span       = 7'((k_eff - 4'd1) * p_eff) + 7'(r_delta_dist);
    assign full       = (r_received == COUNT_MAX);
    assign frame_done = ((4'(r_coef_cnt) + 4'd1) >= n_eff);
    assign recv_next  = FRAME_BITS'(r_received) + FRAME_BITS'(1);
    assign emit_lim   = FRAME_BITS'(r_emitted) + FRAME_BITS'(span);

    assign base_hi  = r_base + FRAME_BITS'(r_delta_dist);
    assign base_lo  = r_base - FRAME_BITS'(r_delta_dist);
    assign item_ok  = (r_base >= FRAME_BITS'(r_delta_dist))
                   && (base_hi < FRAME_BITS'(r_received));
    assign coef_last = ((4'(r_coef) + 4'd1) == n_eff);
    assign blk_last  = ((4'(r_blk) + 4'd1) == k_eff);

    assign addr_wr = {r_wptr, r_coef_cnt};
    assign addr_hi = {base_hi[SLOT_BITS-1:0], r_coef};
    assign addr_lo = {base_lo[SLOT_BITS-1:0], r_coef};

    assign delta = $signed({r_rd_hi[VALUE_BITS-1], r_rd_hi})
                 - $signed({r_rd_lo[VALUE_BITS-1], r_rd_lo});

    assign o_stat.push_emit = frame_done && !full && (recv_next > emit_lim);
    assign o_stat.flush_ok  = (r_emitted < r_received);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.item_last = r_last_q;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_coefs   <= 4'd7;
            r_delta_dist  <= 3'd1;
            r_block_shift <= 4'd3;
            r_num_blocks  <= 4'd7;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NUM_COEFS:   r_num_coefs   <= i_cfg_data;
                REG_DELTA_DIST:  r_delta_dist  <= i_cfg_data[2:0];
                REG_BLOCK_SHIFT: r_block_shift <= i_cfg_data;
                REG_NUM_BLOCKS:  r_num_blocks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame counters and emission indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= '0;
            r_coef_cnt <= '0;
            r_received <= '0;
            r_emitted  <= '0;
            r_base     <= '0;
            r_blk      <= '0;
            r_coef     <= '0;
            r_ok_q     <= 1'b0;
            r_last_q   <= 1'b0;
            r_blk_q    <= '0;
            r_coef_q   <= '0;
        end else begin
            if (i_cmd.start) begin
                r_wptr     <= '0;
                r_coef_cnt <= '0;
                r_received <= '0;
                r_emitted  <= '0;
            end
            if (i_cmd.push && !full) begin
                if (frame_done) begin
                    r_coef_cnt <= '0;
                    r_wptr     <= r_wptr + SLOT_BITS'(1);
                    r_received <= r_received + COUNT_BITS'(1);
                end else begin
                    r_coef_cnt <= r_coef_cnt + COEF_BITS'(1);
                end
            end
            if (i_cmd.emit_begin) begin
                r_base <= FRAME_BITS'(r_emitted);
                r_blk  <= '0;
                r_coef <= '0;
            end
            if (i_cmd.rd) begin
                r_ok_q   <= item_ok;
                r_last_q <= coef_last && blk_last;
                r_blk_q  <= r_blk;
                r_coef_q <= r_coef;
                if (coef_last) begin
                    r_coef <= '0;
                    r_blk  <= r_blk + 3'd1;
                    r_base <= r_base + FRAME_BITS'(p_eff);
                end else begin
                    r_coef <= r_coef + COEF_BITS'(1);
                end
            end
            if (i_cmd.load && r_last_q) begin
                r_emitted <= r_emitted + COUNT_BITS'(1);
            end
        end
    end

    // frame store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_frame_store[addr_wr] <= i_in_data.coef_value;
        end
        if (i_cmd.rd) begin
            r_rd_hi <= r_frame_store[addr_hi];
            r_rd_lo <= r_frame_store[addr_lo];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.delta_value <= r_ok_q ? delta : '0;
            r_out.block_index <= r_blk_q;
            r_out.coef_index  <= 3'(r_coef_q);
            r_out.last        <= r_last_q;
        end
    end

    `SDC_ASSERT_NOW(a_emit_le_recv, 1'b1, r_emitted <= r_received, "more frames sent than received")
    `SDC_ASSERT_NEXT(a_frame_count, i_cmd.load && r_last_q, r_emitted == $past(r_emitted) + COUNT_BITS'(1), "frame end did not advance count")

endmodule

`default_nettype wire

// ===== rtl/shifted_delta_cepstra_unit.sv =====
// ----------------------------------------------------------------------------
// shifted_delta_cepstra_unit
// Streaming shifted delta cepstra: frames of coefficients in, k*N deltas out.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  in       | input     | i_in_valid/o_in_stall | t_in: command, coef_value
//  out      | output    | o_out_valid/i_out_stall | t_out: delta, block, coef, last
//  cfg      | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A push that completes a frame with enough look-ahead, or a flush with a
//  pending frame, sends k*N results, each as a store read and then a load
//  into the output register; the next result is read only after that load.
//  Output stalls stretch the load step; the input is stalled while sending.
//  Synchronous active-low reset clears counters and sets config to defaults;
//  the frame store is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
`default_nettype none

module shifted_delta_cepstra_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input channel
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire sdc_pkg::t_in  i_in_data,
    // output channel
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output sdc_pkg::t_out      o_out_data,
    // config write channel
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [3:0]    i_cfg_data
);
    import sdc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // config writes land directly; user sends them only while idle (unchecked)
    assign o_cfg_ready = 1'b1;

    // sequencer: accepts transactions, steps read/load per result
    sdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_data.command),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // store, counters, subtract and output register
    sdc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule

`default_nettype wire
